// ===== hw/rtl/bd_pkg.sv =====
package bd_pkg;

    localparam int unsigned FIFO_DEPTH  = 8;
    localparam int unsigned FIFO_AW     = 3;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned NRES_W      = 3;

    localparam logic [7:0] PAD_CHAR   = 8'd61;
    localparam logic [6:0] NO_SYMBOL  = 7'd64;
    localparam logic [7:0] SYM62_RST  = 8'd43;
    localparam logic [7:0] SYM63_RST  = 8'd47;

    localparam logic REG_SYMBOL_62 = 1'b0;
    localparam logic REG_SYMBOL_63 = 1'b1;

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_status;
        logic       failed;
        logic       last_of_run;
    } t_out_item;

    typedef t_out_item [MAX_RESULTS-1:0] t_result_vec;

    typedef struct packed {
        logic [1:0]  group_position;
        logic [23:0] group_value;
        logic [2:0]  pad_count;
        logic        stopped;
        logic        error_seen;
    } t_state;

endpackage

// ===== hw/rtl/bd_decode.sv =====
module bd_decode (
    input  bd_pkg::t_state      i_state,
    input  bd_pkg::t_in_item    i_item,
    input  logic [7:0]          i_sym_62,
    input  logic [7:0]          i_sym_63,
    output bd_pkg::t_state      o_state,
    output logic [bd_pkg::NRES_W-1:0] o_count,
    output bd_pkg::t_result_vec o_results
);

    function automatic logic [6:0] symbol_of(input logic [7:0] c, input logic [7:0] s62,
                                             input logic [7:0] s63);
        logic [6:0] r;
        if (c >= 8'd65 && c <= 8'd90) begin
            r = 7'(c - 8'd65);
        end else if (c >= 8'd97 && c <= 8'd122) begin
            r = 7'(c - 8'd71);
        end else if (c >= 8'd48 && c <= 8'd57) begin
            r = 7'(c + 8'd4);
        end else if (c != 8'd0 && c == s62) begin
            r = 7'd62;
        end else if (c != 8'd0 && c == s63) begin
            r = 7'd63;
        end else begin
            r = bd_pkg::NO_SYMBOL;
        end
        return r;
    endfunction

    logic [6:0]               sym;
    logic                     bad;
    logic [bd_pkg::NRES_W-1:0] nres;
    bd_pkg::t_state           st;
    bd_pkg::t_result_vec      res;

    assign sym = symbol_of(i_item.text_char, i_sym_62, i_sym_63);

    always_comb begin
        st   = i_state;
        bad  = 1'b0;
        nres = '0;
        res  = '0;
        if (!i_state.stopped) begin
            if (i_item.text_char == bd_pkg::PAD_CHAR) begin
                if (i_state.pad_count >= 3'd2) begin
                    bad = 1'b1;
                end else begin
                    st.pad_count   = i_state.pad_count + 3'd1;
                    st.group_value = {i_state.group_value[17:0], 6'd0};
                end
            end else if (i_state.group_position == 2'd0 && sym == bd_pkg::NO_SYMBOL) begin
                st.stopped = 1'b1;
            end else if (i_state.pad_count != 3'd0 || sym == bd_pkg::NO_SYMBOL) begin
                bad = 1'b1;
            end else begin
                st.group_value = {i_state.group_value[17:0], sym[5:0]};
            end

            if (bad) begin
                st.error_seen = 1'b1;
                st.stopped    = 1'b1;
            end else if (!st.stopped) begin
                if (i_state.group_position == 2'd3) begin
                    res[0].data_byte = st.group_value[23:16];
                    res[1].data_byte = st.group_value[15:8];
                    res[2].data_byte = st.group_value[7:0];
                    if (st.pad_count == 3'd0) begin
                        nres = 3'd3;
                    end else if (st.pad_count == 3'd1) begin
                        nres = 3'd2;
                    end else begin
                        nres = 3'd1;
                    end
                    st.group_position = 2'd0;
                    st.group_value    = '0;
                    st.pad_count      = '0;
                end else begin
                    st.group_position = i_state.group_position + 2'd1;
                end
            end
        end

        if (i_item.end_of_text) begin
            if (!st.stopped && st.group_position != 2'd0) begin
                st.error_seen = 1'b1;
            end
            res[nres[1:0]].data_byte = 8'd0;
            res[nres[1:0]].is_status = 1'b1;
            res[nres[1:0]].failed    = st.error_seen;
            nres = nres + 3'd1;
            st   = '0;
        end

        for (int k = 0; k < bd_pkg::MAX_RESULTS; k++) begin
            res[k].last_of_run = (nres != 3'd0) && (bd_pkg::NRES_W'(k) == nres - 3'd1);
        end
    end

    assign o_state   = st;
    assign o_count   = nres;
    assign o_results = res;

endmodule

// ===== hw/rtl/base64_decoder_unit.sv =====
// Channel   Valid         Stall         Payload
// input     i_in_valid    o_in_stall    i_in_item  (bd_pkg::t_in_item)
// output    o_out_valid   i_out_stall   o_out_item (bd_pkg::t_out_item)
// config    i_cfg_we      -             i_cfg_index, i_cfg_data
//
// One character is taken per cycle, while the input does not stall, into an input
// register; it is decoded from there, and its results are written to the queue.
// Results go through an 8-entry queue, one per cycle while i_out_stall is low; the
// input stalls while the queue cannot take the four results one character may cause.
// Reset is synchronous, active low; symbols return to '+' and '/'.
module base64_decoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  bd_pkg::t_in_item   i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output bd_pkg::t_out_item  o_out_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    logic [7:0]                     r_sym_62;
    logic [7:0]                     r_sym_63;
    logic                           r_in_valid;
    bd_pkg::t_in_item               r_in;
    bd_pkg::t_state                 r_state;
    bd_pkg::t_state                 n_state;
    bd_pkg::t_out_item              r_fifo [bd_pkg::FIFO_DEPTH];
    logic [bd_pkg::FIFO_AW-1:0]     r_wr;
    logic [bd_pkg::FIFO_AW-1:0]     r_rd;
    logic [bd_pkg::COUNT_W-1:0]     r_count;
    logic [bd_pkg::NRES_W-1:0]      dec_count;
    bd_pkg::t_result_vec            dec_results;
    logic                           advance;
    logic                           pop;
    logic [bd_pkg::NRES_W-1:0]      push_n;

    bd_decode u_decode (
        .i_state   (r_state),
        .i_item    (r_in),
        .i_sym_62  (r_sym_62),
        .i_sym_63  (r_sym_63),
        .o_state   (n_state),
        .o_count   (dec_count),
        .o_results (dec_results)
    );

    assign advance     = r_in_valid &&
                         (r_count <= bd_pkg::COUNT_W'(bd_pkg::FIFO_DEPTH - bd_pkg::MAX_RESULTS));
    assign o_in_stall  = r_in_valid && !advance;
    assign push_n      = advance ? dec_count : '0;
    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_out_item  = r_fifo[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_62 <= bd_pkg::SYM62_RST;
            r_sym_63 <= bd_pkg::SYM63_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bd_pkg::REG_SYMBOL_62: r_sym_62 <= i_cfg_data;
                bd_pkg::REG_SYMBOL_63: r_sym_63 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
            r_wr       <= '0;
            r_rd       <= '0;
            r_count    <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
            r_wr    <= r_wr + bd_pkg::FIFO_AW'(push_n);
            r_rd    <= r_rd + bd_pkg::FIFO_AW'(pop);
            r_count <= r_count + bd_pkg::COUNT_W'(push_n) - bd_pkg::COUNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < bd_pkg::MAX_RESULTS; k++) begin
            if (bd_pkg::NRES_W'(k) < push_n) begin
                r_fifo[r_wr + bd_pkg::FIFO_AW'(k)] <= dec_results[k];
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bd_pkg::COUNT_W'(bd_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
        r_count == $past(r_count) + bd_pkg::COUNT_W'($past(push_n))
                   - bd_pkg::COUNT_W'($past(pop)))
        else $error("queue count out of step");

    a_eot_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.end_of_text) |=> r_state == '0)
        else $error("state not cleared after end of text");

    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_state.stopped && !r_in.end_of_text) |-> dec_count == '0)
        else $error("result after stop");
`endif

endmodule

// ===== tb/tb_base64_decoder_unit.sv =====
`timescale 1ns / 100ps

module tb_base64_decoder_unit;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 6;
    localparam int LIVE_PER_PHASE = 18;
    localparam logic [31:0] MAN_WORD = "TWFu";

    typedef enum {TXT_CLEAN, TXT_BAD_CHAR, TXT_EXTRA_PAD, TXT_SHORT, TXT_NOISE} t_text_kind;

    typedef struct packed {
        logic [7:0]  ch;
        logic        eot;
        logic        typed;
        logic [1:0]  nb;
        logic [23:0] word;
        logic        fail;
    } t_dir_row;

    // ch, eot, typed, byte count, bytes, failed
    localparam t_dir_row DIR_ROWS [25] = '{
        '{"+",   1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"/",   1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"+",   1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"/",   1'b0, 1'b1, 2'd3, 24'hfbffbf, 1'b0},
        '{"T",   1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"Q",   1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"=",   1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"=",   1'b0, 1'b1, 2'd1, 24'h4d0000, 1'b0},
        '{"T",   1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"W",   1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"E",   1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"=",   1'b1, 1'b1, 2'd2, 24'h4d6100, 1'b0},
        '{"A",   1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"=",   1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"=",   1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"=",   1'b1, 1'b1, 2'd0, 24'h000000, 1'b1},
        '{"A",   1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"=",   1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"B",   1'b1, 1'b1, 2'd0, 24'h000000, 1'b1},
        '{"T",   1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{8'h00, 1'b1, 1'b1, 2'd0, 24'h000000, 1'b1},
        '{8'hff, 1'b0, 1'b1, 2'd0, 24'h000000, 1'b0},
        '{"A",   1'b1, 1'b1, 2'd0, 24'h000000, 1'b0},
        '{"T",   1'b0, 1'b0, 2'd0, 24'h000000, 1'b0},
        '{"W",   1'b1, 1'b1, 2'd0, 24'h000000, 1'b1}
    };

    // {symbol_62, symbol_63} per random phase
    localparam logic [15:0] SYM_SETS [6] = '{
        {8'h00, 8'hff}, {"-", "_"}, {"=", 8'h00}, {8'hff, 8'hff}, {"7", "Z"}, {"+", "/"}
    };

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    bd_pkg::t_in_item  in_item   = '0;
    logic              out_stall = 1'b0;
    logic              cfg_we    = 1'b0;
    logic              cfg_index = 1'b0;
    logic [7:0]        cfg_data  = 8'h00;
    logic              in_stall;
    logic              out_valid;
    bd_pkg::t_out_item out_item;

    // decoder state mirror
    logic [7:0]  sym62     = bd_pkg::SYM62_RST;
    logic [7:0]  sym63     = bd_pkg::SYM63_RST;
    logic [1:0]  grp_pos   = 2'd0;
    logic [23:0] grp_val   = 24'd0;
    logic [2:0]  pad_cnt   = 3'd0;
    logic        halted    = 1'b0;
    logic        malformed = 1'b0;

    bd_pkg::t_out_item decoded_q [$];
    bd_pkg::t_out_item typed_res [$];
    bit        typed_set  = 1'b0;
    bit        gap_en     = 1'b1;
    bit        stall_en   = 1'b1;
    bit        hold_off   = 1'b0;
    int        live_chars = 0;
    int        errors     = 0;

    base64_decoder_unit u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic bd_pkg::t_out_item make_result(input logic [7:0] b, input logic st,
                                                      input logic f);
        bd_pkg::t_out_item r;
        r.data_byte   = b;
        r.is_status   = st;
        r.failed      = f;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    function automatic void mark_last(inout bd_pkg::t_out_item q [$]);
        bd_pkg::t_out_item r;
        if (q.size() == 0) return;
        r = q.pop_back();
        r.last_of_run = 1'b1;
        q.push_back(r);
    endfunction

    function automatic int char_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return int'(c) - 65;
        if (c >= "a" && c <= "z") return int'(c) - 71;
        if (c >= "0" && c <= "9") return int'(c) + 4;
        if (c != 8'h00 && c == sym62) return 62;
        if (c != 8'h00 && c == sym63) return 63;
        return int'(bd_pkg::NO_SYMBOL);
    endfunction

    function automatic logic [7:0] enc_char(input int v);
        if (v < 26) return 8'(65 + v);
        if (v < 52) return 8'(71 + v);
        if (v < 62) return 8'(v - 4);
        return (v == 62) ? sym62 : sym63;
    endfunction

    function automatic void decode_char(input logic [7:0] c, input logic eot,
                                        output bd_pkg::t_out_item res [$]);
        int  v;
        bit  bad;
        res.delete();
        bad = 1'b0;
        if (!halted) begin
            v = char_value(c);
            if (c == bd_pkg::PAD_CHAR) begin
                if (pad_cnt >= 3'd2) begin
                    bad = 1'b1;
                end else begin
                    pad_cnt = pad_cnt + 3'd1;
                    grp_val = {grp_val[17:0], 6'd0};
                end
            end else if (grp_pos == 2'd0 && v == int'(bd_pkg::NO_SYMBOL)) begin
                halted = 1'b1;
            end else if (pad_cnt != 3'd0 || v == int'(bd_pkg::NO_SYMBOL)) begin
                bad = 1'b1;
            end else begin
                grp_val = {grp_val[17:0], 6'(v)};
            end

            if (bad) begin
                malformed = 1'b1;
                halted    = 1'b1;
            end else if (!halted) begin
                if (grp_pos == 2'd3) begin
                    res.push_back(make_result(grp_val[23:16], 1'b0, 1'b0));
                    if (pad_cnt < 3'd2) res.push_back(make_result(grp_val[15:8], 1'b0, 1'b0));
                    if (pad_cnt < 3'd1) res.push_back(make_result(grp_val[7:0], 1'b0, 1'b0));
                    grp_pos = 2'd0;
                    grp_val = 24'd0;
                    pad_cnt = 3'd0;
                end else begin
                    grp_pos = grp_pos + 2'd1;
                end
            end
        end

        if (eot) begin
            if (!halted && grp_pos != 2'd0) malformed = 1'b1;
            res.push_back(make_result(8'h00, 1'b1, malformed));
            grp_pos   = 2'd0;
            grp_val   = 24'd0;
            pad_cnt   = 3'd0;
            halted    = 1'b0;
            malformed = 1'b0;
        end
        mark_last(res);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eot);
        bd_pkg::t_out_item res [$];
        int                gap;
        in_valid <= 1'b1;
        in_item  <= '{text_char: c, end_of_text: eot};
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        if (!halted) live_chars++;
        decode_char(c, eot, res);
        if (typed_set) begin
            res       = typed_res;
            typed_set = 1'b0;
        end
        foreach (res[i]) decoded_q.push_back(res[i]);
        if (gap_en && $urandom_range(0, 2) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_text();
        logic [7:0] txt [$];
        int         ngrp;
        int         npad;
        int         pos;
        int         n;
        t_text_kind kind;
        ngrp = $urandom_range(1, 3);
        npad = $urandom_range(0, 2);
        for (n = 0; n < 4 * ngrp; n++) txt.push_back(enc_char($urandom_range(0, 63)));
        if (npad > 0) txt[txt.size() - 1] = bd_pkg::PAD_CHAR;
        if (npad > 1) txt[txt.size() - 2] = bd_pkg::PAD_CHAR;
        pos = $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 9))
            0: kind = TXT_BAD_CHAR;
            1: kind = TXT_EXTRA_PAD;
            2: kind = TXT_SHORT;
            3: kind = TXT_NOISE;
            default: kind = TXT_CLEAN;
        endcase
        case (kind)
            TXT_BAD_CHAR:  txt[pos] = 8'($urandom_range(0, 255));
            TXT_EXTRA_PAD: txt[pos] = bd_pkg::PAD_CHAR;
            TXT_SHORT:     while (txt.size() > pos + 1) void'(txt.pop_back());
            TXT_NOISE:     foreach (txt[j]) txt[j] = 8'($urandom_range(0, 255));
            default: ;
        endcase
        // occasional early end of text mid-stream
        foreach (txt[j])
            send_char(txt[j], (j == txt.size() - 1) || ($urandom_range(0, 24) == 0));
    endtask

    task automatic set_symbols(input logic [7:0] s62, input logic [7:0] s63);
        cfg_we    <= 1'b1;
        cfg_index <= bd_pkg::REG_SYMBOL_62;
        cfg_data  <= s62;
        @(posedge clk);
        cfg_index <= bd_pkg::REG_SYMBOL_63;
        cfg_data  <= s63;
        @(posedge clk);
        cfg_we <= 1'b0;
        sym62 = s62;
        sym63 = s63;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    initial begin : out_stall_gen
        int n;
        forever begin
            @(posedge clk);
            if (hold_off) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
                out_stall <= 1'b0;
            end else if (stall_en && $urandom_range(0, 3) == 0) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin : result_check
        bd_pkg::t_out_item want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, got %h", $time, out_item);
                errors++;
            end else begin
                want = decoded_q.pop_front();
                check_field("data_byte", want.data_byte, out_item.data_byte);
                check_field("is_status", 8'(want.is_status), 8'(out_item.is_status));
                check_field("failed", 8'(want.failed), 8'(out_item.failed));
                check_field("last_of_run", 8'(want.last_of_run), 8'(out_item.last_of_run));
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int k;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].typed) begin
                typed_res.delete();
                for (k = 0; k < int'(DIR_ROWS[i].nb); k++)
                    typed_res.push_back(make_result(DIR_ROWS[i].word[23 - 8 * k -: 8],
                                                    1'b0, 1'b0));
                if (DIR_ROWS[i].eot)
                    typed_res.push_back(make_result(8'h00, 1'b1, DIR_ROWS[i].fail));
                mark_last(typed_res);
                typed_set = 1'b1;
            end
            send_char(DIR_ROWS[i].ch, DIR_ROWS[i].eot);
        end
        wait_drain();

        // receiver holds off while the sender keeps going, so the input backs up
        gap_en   = 1'b0;
        hold_off = 1'b1;
        for (k = 0; k < 16; k++) send_char(MAN_WORD[31 - 8 * (k % 4) -: 8], k == 15);
        wait_drain();

        foreach (SYM_SETS[p]) begin
            set_symbols(SYM_SETS[p][15:8], SYM_SETS[p][7:0]);
            gap_en     = (p % 2 == 1);
            stall_en   = (p % 3 != 2);
            live_chars = 0;
            while (live_chars < LIVE_PER_PHASE) send_random_text();
            wait_drain();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
